>>> hdl/page_table_walk_update_core_defines.svh
// assertion macros used by the page table walker datapath
`ifndef PAGE_TABLE_WALK_UPDATE_CORE_DEFINES_SVH
`define PAGE_TABLE_WALK_UPDATE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PTWU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptwu: same-cycle check failed");

// next-cycle implication, checked out of reset
`define PTWU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptwu: next-cycle check failed");

`endif

>>> hdl/ptwu_pkg.sv
package ptwu_pkg;

  localparam int FRAMES  = 16;
  localparam int LEVELS  = 5;
  localparam int ENTRIES = 512;
  localparam int IDX_W   = 9;
  localparam int FW      = $clog2(FRAMES);
  localparam int AW      = FW + IDX_W;
  localparam int DEPTH   = FRAMES * ENTRIES;
  localparam int EPOCH_W = 6;
  localparam int LVL_W   = $clog2(LEVELS + 1);
  localparam int FF_W    = 5;
  localparam int ROOT_W  = 4;
  localparam int NF_W    = ($clog2(FRAMES + 1) > FF_W) ? $clog2(FRAMES + 1) : FF_W;
  localparam int VPN_W   = 45;
  localparam int PFN_W   = 52;
  localparam int ACT_W   = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);
  localparam logic [NF_W-1:0]  FIRST_FREE_RST = NF_W'(1);

  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MAP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_UNMAP = 2'd2;

  localparam logic [PADDR_W-3:0] REG_ROOT_FRAME = 1'd0;
  localparam logic [PADDR_W-3:0] REG_FIRST_FREE = 1'd1;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [VPN_W-1:0] vpn;
    logic [PFN_W-1:0] target_frame;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [PFN_W-1:0] mapped_frame;
    logic             out_of_frames;
  } rsp_t;

  // stored entry: tag must match the frame's epoch for the entry to count
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [PFN_W-1:0]   frame;
    logic               v;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [ROOT_W-1:0] root_frame;
    logic [FF_W-1:0]   first_free;
    logic              reload;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR_ALL,
    OP_ACCEPT,
    OP_WALK_RD,
    OP_WALK_EVAL,
    OP_CHECK,
    OP_ALLOC_RD,
    OP_ALLOC_EP,
    OP_CLR_FRAME,
    OP_LINK,
    OP_LEAF,
    OP_UNMAP,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic in_wait;
    logic out_wait;
    logic all_more;
    logic frame_more;
    logic descend;
    logic map_ok;
    logic need_zero;
    logic wrap;
    logic need_more;
  } status_t;

  function automatic logic [IDX_W-1:0] level_index(logic [VPN_W-1:0] v,
                                                   logic [LVL_W-1:0] lvl);
    logic [VPN_W-1:0] s;
    s = v >> (IDX_W * (LEVELS - 1 - int'(lvl)));
    return s[IDX_W-1:0];
  endfunction

endpackage

>>> hdl/ptwu_ram.sv
module ptwu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ptwu_seq.sv
module ptwu_seq (
  input  logic              clk,
  input  logic              rst,
  input  ptwu_pkg::status_t status,
  output ptwu_pkg::ctrl_t   ctrl
);

  import ptwu_pkg::*;

  typedef enum logic [3:0] {
    S_CLR  = 4'd0,
    S_IDLE = 4'd1,
    S_RD   = 4'd2,
    S_EVAL = 4'd3,
    S_DISP = 4'd4,
    S_NEED = 4'd5,
    S_ARD  = 4'd6,
    S_AEP  = 4'd7,
    S_FCLR = 4'd8,
    S_LINK = 4'd9,
    S_LEAF = 4'd10,
    S_UNM  = 4'd11,
    S_OUT  = 4'd12
  } step_t;

  typedef enum logic [1:0] {
    W_NONE,
    W_IN,
    W_OUT
  } wait_t;

  typedef enum logic [3:0] {
    B_NONE,
    B_ALWAYS,
    B_ALL_MORE,
    B_FRAME_MORE,
    B_DESCEND,
    B_NOT_MAP_OK,
    B_NEED_ZERO,
    B_NO_WRAP,
    B_NEED_MORE
  } br_t;

  typedef struct packed {
    op_t   op;
    wait_t wt;
    br_t   br;
    step_t target;
  } uword_t;

  // microcode store: one word per step
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{OP_NOP, W_NONE, B_NONE, S_IDLE};
    unique case (s)
      S_CLR:   w = '{OP_CLR_ALL,   W_NONE, B_ALL_MORE,   S_CLR};
      S_IDLE:  w = '{OP_ACCEPT,    W_IN,   B_NONE,       S_IDLE};
      S_RD:    w = '{OP_WALK_RD,   W_NONE, B_NONE,       S_IDLE};
      S_EVAL:  w = '{OP_WALK_EVAL, W_NONE, B_DESCEND,    S_RD};
      S_DISP:  w = '{OP_CHECK,     W_NONE, B_NOT_MAP_OK, S_UNM};
      S_NEED:  w = '{OP_NOP,       W_NONE, B_NEED_ZERO,  S_LEAF};
      S_ARD:   w = '{OP_ALLOC_RD,  W_NONE, B_NONE,       S_IDLE};
      S_AEP:   w = '{OP_ALLOC_EP,  W_NONE, B_NO_WRAP,    S_LINK};
      S_FCLR:  w = '{OP_CLR_FRAME, W_NONE, B_FRAME_MORE, S_FCLR};
      S_LINK:  w = '{OP_LINK,      W_NONE, B_NEED_MORE,  S_ARD};
      S_LEAF:  w = '{OP_LEAF,      W_NONE, B_ALWAYS,     S_OUT};
      S_UNM:   w = '{OP_UNMAP,     W_NONE, B_NONE,       S_IDLE};
      S_OUT:   w = '{OP_FINISH,    W_OUT,  B_ALWAYS,     S_IDLE};
      default: w = '{OP_NOP,       W_NONE, B_ALWAYS,     S_IDLE};
    endcase
    return w;
  endfunction

  step_t  pc;
  step_t  pc_next;
  uword_t word;
  logic   hold;
  logic   take;

  assign word = ucode(pc);
  assign ctrl.op = word.op;

  always_comb begin
    unique case (word.wt)
      W_IN:    hold = status.in_wait;
      W_OUT:   hold = status.out_wait;
      default: hold = 1'b0;
    endcase
  end

  always_comb begin
    unique case (word.br)
      B_ALWAYS:     take = 1'b1;
      B_ALL_MORE:   take = status.all_more;
      B_FRAME_MORE: take = status.frame_more;
      B_DESCEND:    take = status.descend;
      B_NOT_MAP_OK: take = !status.map_ok;
      B_NEED_ZERO:  take = status.need_zero;
      B_NO_WRAP:    take = !status.wrap;
      B_NEED_MORE:  take = status.need_more;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    priority if (hold) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = word.target;
    end else begin
      pc_next = step_t'(pc + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_CLR;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> hdl/ptwu_dp.sv
`include "page_table_walk_update_core_defines.svh"

module ptwu_dp (
  input  logic              clk,
  input  logic              rst,
  input  ptwu_pkg::ctrl_t   ctrl,
  output ptwu_pkg::status_t status,
  input  ptwu_pkg::cfg_t    cfg,
  input  logic              req_valid,
  output logic              req_ready,
  input  ptwu_pkg::req_t    req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output ptwu_pkg::rsp_t    rsp
);

  import ptwu_pkg::*;

  // item and walk registers
  logic [ACT_W-1:0]   act;
  logic [VPN_W-1:0]   vpn;
  logic [PFN_W-1:0]   target;
  logic [PFN_W-1:0]   frame;
  logic [LVL_W-1:0]   level;
  logic [LVL_W-1:0]   need;
  logic               present;
  logic               found;
  logic [PFN_W-1:0]   leaf;
  logic               oof;
  logic [EPOCH_W-1:0] cur_ep;
  logic [EPOCH_W-1:0] new_ep;
  logic [AW-1:0]      addr;
  logic [AW-1:0]      cnt;
  logic [NF_W-1:0]    next_free;

  // memory ports
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  entry_t             mem_wdata;
  logic [AW-1:0]      mem_raddr;
  entry_t             mem_q;
  logic               ep_we;
  logic [FW-1:0]      ep_waddr;
  logic [EPOCH_W-1:0] ep_wdata;
  logic [FW-1:0]      ep_raddr;
  logic [EPOCH_W-1:0] ep_q;

  logic               req_xfer;
  logic               out_load;
  logic               frame_ok;
  logic               entry_ok;
  logic [LVL_W-1:0]   need_calc;
  logic [NF_W-1:0]    avail;
  logic [EPOCH_W-1:0] ep_inc;
  logic [LVL_W-1:0]   level_up;
  logic [AW-1:0]      walk_addr;

  ptwu_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_frames (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  // one epoch per frame; bumping it empties the frame at once unless the epoch wraps
  ptwu_ram #(.WIDTH(EPOCH_W), .DEPTH(FRAMES)) u_epochs (
    .clk   (clk),
    .we    (ep_we),
    .waddr (ep_waddr),
    .wdata (ep_wdata),
    .raddr (ep_raddr),
    .rdata (ep_q)
  );

  assign req_ready = (ctrl.op == OP_ACCEPT);
  assign req_xfer  = req_ready && req_valid;
  assign out_load  = (ctrl.op == OP_FINISH) && (!rsp_valid || rsp_ready);

  assign frame_ok  = frame < PFN_W'(FRAMES);
  assign entry_ok  = mem_q.v && (mem_q.tag == ep_q);
  assign level_up  = level + LVL_W'(1);
  assign walk_addr = {frame[FW-1:0], level_index(vpn, level)};
  assign need_calc = found ? '0 : (LAST_LVL - level);
  assign avail     = (next_free < NF_W'(FRAMES)) ? (NF_W'(FRAMES) - next_free) : '0;
  assign ep_inc    = (ep_q == '1) ? '0 : (ep_q + EPOCH_W'(1));

  assign status.in_wait    = !req_valid;
  assign status.out_wait   = rsp_valid && !rsp_ready;
  assign status.all_more   = cnt != AW'(DEPTH - 1);
  assign status.frame_more = cnt[IDX_W-1:0] != '1;
  assign status.descend    = frame_ok && entry_ok && (level != LAST_LVL);
  assign status.map_ok     = (act == ACT_MAP) && present &&
                             (NF_W'(need_calc) <= avail);
  assign status.need_zero  = need == '0;
  assign status.wrap       = ep_q == '1;
  assign status.need_more  = need != LVL_W'(1);

  assign mem_raddr = walk_addr;
  assign ep_raddr  = (ctrl.op == OP_ALLOC_RD) ? next_free[FW-1:0] : frame[FW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = '0;
    ep_we     = 1'b0;
    ep_waddr  = next_free[FW-1:0];
    ep_wdata  = ep_inc;
    unique case (ctrl.op)
      OP_CLR_ALL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        ep_we     = 1'b1;
        ep_waddr  = cnt[FW-1:0];
        ep_wdata  = '0;
      end
      OP_ALLOC_EP: begin
        ep_we = 1'b1;
      end
      OP_CLR_FRAME: begin
        mem_we    = 1'b1;
        mem_waddr = {next_free[FW-1:0], cnt[IDX_W-1:0]};
      end
      OP_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = '{tag: cur_ep, frame: PFN_W'(next_free), v: 1'b1};
      end
      OP_LEAF: begin
        mem_we    = 1'b1;
        mem_wdata = '{tag: cur_ep, frame: target, v: 1'b1};
      end
      OP_UNMAP: begin
        // an entry with its valid bit clear reads as empty whatever else it holds
        mem_we = (act == ACT_UNMAP) && present;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      next_free <= FIRST_FREE_RST;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.reload) begin
        next_free <= NF_W'(cfg.first_free);
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (ctrl.op)
        OP_CLR_ALL:   cnt <= cnt + AW'(1);
        OP_ALLOC_EP:  cnt <= '0;
        OP_CLR_FRAME: cnt <= cnt + AW'(1);
        OP_LINK:      next_free <= next_free + NF_W'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.found         <= found;
      rsp.mapped_frame  <= leaf;
      rsp.out_of_frames <= oof;
    end
    unique case (ctrl.op)
      OP_ACCEPT: begin
        if (req_valid) begin
          act     <= req.action;
          vpn     <= req.vpn;
          target  <= req.target_frame;
          frame   <= PFN_W'(cfg.root_frame);
          level   <= '0;
          present <= 1'b0;
          found   <= 1'b0;
          leaf    <= '0;
          oof     <= 1'b0;
        end
      end
      OP_WALK_RD: begin
        addr <= walk_addr;
      end
      OP_WALK_EVAL: begin
        present <= frame_ok;
        if (frame_ok) begin
          cur_ep <= ep_q;
          if (entry_ok) begin
            if (level == LAST_LVL) begin
              found <= 1'b1;
              leaf  <= mem_q.frame;
            end else begin
              frame <= mem_q.frame;
              level <= level_up;
            end
          end
        end
      end
      OP_CHECK: begin
        need <= need_calc;
        oof  <= (act == ACT_MAP) && present && (NF_W'(need_calc) > avail);
      end
      OP_ALLOC_EP: begin
        new_ep <= ep_inc;
        // the parent may sit in the frame being handed out
        if (frame == PFN_W'(next_free)) begin
          cur_ep <= ep_inc;
        end
      end
      OP_LINK: begin
        addr   <= {next_free[FW-1:0], level_index(vpn, level_up)};
        frame  <= PFN_W'(next_free);
        cur_ep <= new_ep;
        level  <= level_up;
        need   <= need - LVL_W'(1);
      end
      default: begin
      end
    endcase
  end

  `PTWU_ASSERT_NOW(a_alloc_in_range, ctrl.op == OP_LINK, next_free < NF_W'(FRAMES))
  `PTWU_ASSERT_NOW(a_oof_only_unfound_map, out_load && oof, (act == ACT_MAP) && !found)
  `PTWU_ASSERT_NOW(a_leaf_zero_unfound, out_load && !found, leaf == '0)
  `PTWU_ASSERT_NEXT(a_accept_clears, req_xfer, !found && !oof && (level == '0))

endmodule

>>> hdl/page_table_walk_update_core.sv
// five-level page table walker over an internal frame store of FRAMES x 512 entries
// req channel (valid/ready) carries action, vpn and target_frame; action 0 queries,
// 1 maps vpn to target_frame, 2 unmaps, 3 behaves as a query
// rsp channel (valid/ready) returns found, mapped_frame and out_of_frames, one per request
// apb port: root_frame at 0x0, first_free_frame at 0x4 (writing it reloads the allocator)
// a request is taken only while the block is idle; one request is in flight at a time
// from request transfer to rsp valid, every level walked takes a read of the frame
// store and of the frame epoch, then an evaluate step; then a check follows, and a query,
// an unmap or a map that runs out of frames goes on through the unmap and finish steps;
// a map that writes instead allocates each frame it needs (epoch read, epoch bump, link)
// and then writes the leaf before the finish step; the next request can be taken in the
// cycle after rsp is loaded
// allocating a frame normally just bumps its epoch; every 64th reuse of the same frame
// also sweeps its 512 entries, one per cycle
// after reset all FRAMES*512 entries of the store (8192) and all frame epochs are
// cleared before the first request is taken; apb writes are taken during that time
// rsp is held in an output register, so the next request is accepted while it waits;
// a stalled rsp only holds the sequencer once the following result is ready
module page_table_walk_update_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  ptwu_pkg::req_t                   req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output ptwu_pkg::rsp_t                   rsp,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ptwu_pkg::PADDR_W-1:0]     paddr,
  input  logic [ptwu_pkg::PDATA_W-1:0]     pwdata,
  output logic [ptwu_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  import ptwu_pkg::*;

  logic [ROOT_W-1:0]    root_frame;
  logic [FF_W-1:0]      first_free;
  logic                 wr_xfer;
  logic [PADDR_W-3:0]   reg_idx;
  ctrl_t                ctrl;
  status_t              status;
  cfg_t                 cfg;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_xfer = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_frame <= '0;
      first_free <= FF_W'(FIRST_FREE_RST);
    end else if (wr_xfer) begin
      unique case (reg_idx)
        REG_ROOT_FRAME: root_frame <= pwdata[ROOT_W-1:0];
        REG_FIRST_FREE: first_free <= pwdata[FF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROOT_FRAME: prdata = PDATA_W'(root_frame);
      REG_FIRST_FREE: prdata = PDATA_W'(first_free);
      default:        prdata = '0;
    endcase
  end

  assign cfg.root_frame = root_frame;
  assign cfg.first_free = pwdata[FF_W-1:0];
  assign cfg.reload     = wr_xfer && (reg_idx == REG_FIRST_FREE);

  ptwu_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  ptwu_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
